// ----- sv/hics_pkg.sv -----
// Shared types, widths and codes for the histogram inverse-CDF sampler.
// Depends on nothing; every other file of the block imports it.
package hics_pkg;

  localparam int MAX_BINS = 512;
  localparam int ADDR_W   = $clog2(MAX_BINS);

  // Field widths of the channels.
  localparam int OP_W      = 1;
  localparam int IDX_W     = 9;
  localparam int W_W       = 16;
  localparam int U_W       = 24;
  localparam int E_OUT_W   = 25;
  localparam int BIN_OUT_W = 9;

  // Configuration register widths.
  localparam int BW_W  = 8;
  localparam int BIU_W = 10;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Datapath widths.
  localparam int FRAC_W = 8;                       // fraction bits of the energy
  localparam int TOT_W  = W_W + ADDR_W;            // running total of all weights
  localparam int TGT_W  = TOT_W + U_W;             // u * total
  localparam int D_W    = W_W + U_W;               // overshoot inside the hit bin
  localparam int NUM_W  = D_W + BW_W;              // overshoot * bin width
  localparam int DEN_W  = W_W + U_W - FRAC_W;      // bin weight * 2^16
  localparam int QUO_W  = BW_W + FRAC_W;           // subtracted fraction
  localparam int PROD_W = ADDR_W + BW_W;           // bin * bin width
  localparam int E_W    = PROD_W + FRAC_W;         // unsaturated energy

  localparam int ENERGY_MAX = (1 << E_OUT_W) - 1;

  localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE = CFG_IDX_W'(1);

  localparam logic [BW_W-1:0]  BW_RESET  = BW_W'(200);
  localparam logic [BIU_W-1:0] BIU_RESET = BIU_W'(53);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_DRAW  = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef enum logic [1:0] {
    RES_CALC,
    RES_ZERO,
    RES_EMPTY
  } res_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      accept;
    logic      clr_step;
    logic      wr_read;
    logic      wr_update;
    logic      draw_start;
    logic      walk;
    logic      sub;
    logic      mul;
    logic      div_start;
    logic      load_out;
    res_kind_t kind;
  } hics_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic op;
    logic total_zero;
    logic hit;
    logic miss;
    logic at_first;
    logic div_done;
    logic out_free;
  } hics_stat_t;

endpackage

// ----- sv/hics_if.sv -----
// Valid/ready channel interfaces of the sampler: input items, results, configuration.
// Depends on hics_pkg for the field widths.
interface hics_in_if;
  import hics_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [IDX_W-1:0] bin_index;
  logic [W_W-1:0]   bin_weight;
  logic [U_W-1:0]   uniform_value;

  modport source (output valid, opcode, bin_index, bin_weight, uniform_value, input ready);
  modport sink   (input valid, opcode, bin_index, bin_weight, uniform_value, output ready);
endinterface

interface hics_out_if;
  import hics_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [E_OUT_W-1:0]   energy;
  logic [BIN_OUT_W-1:0] chosen_bin;
  logic                 status;

  modport source (output valid, energy, chosen_bin, status, input ready);
  modport sink   (input valid, energy, chosen_bin, status, output ready);
endinterface

interface hics_cfg_if;
  import hics_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/hics_div.sv -----
// Restoring divider producing one quotient bit per cycle.
// Depends on hics_pkg for the operand widths.
module hics_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [hics_pkg::NUM_W-1:0]    num,
  input  logic [hics_pkg::DEN_W-1:0]    den,
  output logic                          done,
  output logic [hics_pkg::QUO_W-1:0]    quo
);
  import hics_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] lo_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic             ge;

  // The low register shifts numerator bits out and quotient bits in.
  always_comb begin
    trial   = {rem_r, lo_r[QUO_W-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUO_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[NUM_W-1:QUO_W];
      lo_r  <= num[QUO_W-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lo_r  <= {lo_r[QUO_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = lo_r;

endmodule

// ----- sv/hics_dp.sv -----
// Datapath of the sampler: weight memory, total, configuration, walk, multiply, divide, result.
// Depends on hics_pkg and instantiates hics_div.
module hics_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hics_pkg::hics_cmd_t               cmd,
  output hics_pkg::hics_stat_t              stat,
  input  logic [hics_pkg::OP_W-1:0]         in_opcode,
  input  logic [hics_pkg::IDX_W-1:0]        in_bin_index,
  input  logic [hics_pkg::W_W-1:0]          in_bin_weight,
  input  logic [hics_pkg::U_W-1:0]          in_uniform_value,
  input  logic                              cfg_we,
  input  logic [hics_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hics_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [hics_pkg::E_OUT_W-1:0]      out_energy,
  output logic [hics_pkg::BIN_OUT_W-1:0]    out_chosen_bin,
  output logic                              out_status
);
  import hics_pkg::*;

  // Weight memory with registered read data.
  logic [W_W-1:0]    mem [MAX_BINS];
  logic [W_W-1:0]    rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [W_W-1:0]    mem_wd;

  // Captured input item.
  logic [OP_W-1:0]   op_r;
  logic [IDX_W-1:0]  idx_r;
  logic [W_W-1:0]    wgt_r;
  logic [U_W-1:0]    u_r;

  // Configuration and table total.
  logic [BW_W-1:0]   bw_r;
  logic [BIU_W-1:0]  biu_r;
  logic [TOT_W-1:0]  total_r;

  // Walk and arithmetic.
  logic [ADDR_W-1:0] di_r;
  logic [ADDR_W-1:0] last_r;
  logic [ADDR_W-1:0] chosen_r;
  logic [W_W-1:0]    w_r;
  logic [TOT_W-1:0]  sum_r, sum_nxt;
  logic [TGT_W-1:0]  target_r;
  logic [D_W-1:0]    d_r;
  logic [NUM_W-1:0]  num_r;
  logic [PROD_W-1:0] prod_r;
  logic              hit;

  logic [31:0]       idx32, biu32, n32;
  logic [ADDR_W-1:0] wr_addr;
  logic              in_range;

  logic              div_done;
  logic [QUO_W-1:0]  quo;
  logic [E_W-1:0]    e_calc;
  logic              e_sat;

  logic                 out_valid_r;
  logic [E_OUT_W-1:0]   energy_r;
  logic [BIN_OUT_W-1:0] chosen_bin_r;
  logic                 status_r;

  always_comb begin
    idx32    = 32'(idx_r);
    in_range = idx32 < 32'(MAX_BINS);
    wr_addr  = ADDR_W'(idx32);

    biu32 = 32'(biu_r);
    if (biu32 == 32'd0) begin
      n32 = 32'd1;
    end else if (biu32 > 32'(MAX_BINS)) begin
      n32 = 32'(MAX_BINS);
    end else begin
      n32 = biu32;
    end

    rd_addr = di_r + ADDR_W'(1);
    if (cmd.wr_read) begin
      rd_addr = wr_addr;
    end else if (cmd.draw_start) begin
      rd_addr = '0;
    end

    mem_we = cmd.clr_step | (cmd.wr_update & in_range);
    mem_wa = cmd.clr_step ? di_r : wr_addr;
    mem_wd = cmd.clr_step ? '0 : wgt_r;

    sum_nxt = sum_r + TOT_W'(rd_data_r);
    hit     = {sum_nxt, {U_W{1'b0}}} >= target_r;

    e_calc = {prod_r, {FRAC_W{1'b0}}} - E_W'(quo);
    e_sat  = e_calc > E_W'(ENERGY_MAX);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Control state: configuration, total, index counter, result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r        <= BW_RESET;
      biu_r       <= BIU_RESET;
      total_r     <= '0;
      di_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BIN_WIDTH:   bw_r  <= cfg_data[BW_W-1:0];
          REG_BINS_IN_USE: biu_r <= cfg_data[BIU_W-1:0];
          default: ;
        endcase
      end

      if (cmd.wr_update && in_range) begin
        total_r <= total_r - TOT_W'(rd_data_r) + TOT_W'(wgt_r);
      end

      if (cmd.clr_step) begin
        di_r <= stat.clr_last ? '0 : di_r + ADDR_W'(1);
      end else if (cmd.draw_start) begin
        di_r <= '0;
      end else if (cmd.walk) begin
        di_r <= di_r + ADDR_W'(1);
      end

      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_opcode;
      idx_r <= in_bin_index;
      wgt_r <= in_bin_weight;
      u_r   <= in_uniform_value;
    end
    if (cmd.draw_start) begin
      target_r <= TGT_W'(u_r) * TGT_W'(total_r);
      last_r   <= ADDR_W'(n32 - 32'd1);
      sum_r    <= '0;
    end
    if (cmd.walk) begin
      sum_r    <= sum_nxt;
      chosen_r <= di_r;
      w_r      <= rd_data_r;
    end
    if (cmd.sub) begin
      d_r    <= D_W'({sum_r, {U_W{1'b0}}} - target_r);
      prod_r <= PROD_W'(chosen_r) * PROD_W'(bw_r);
    end
    if (cmd.mul) begin
      num_r <= NUM_W'(d_r) * NUM_W'(bw_r);
    end
    if (cmd.load_out) begin
      unique case (cmd.kind)
        RES_CALC: begin
          energy_r     <= e_sat ? '1 : E_OUT_W'(e_calc);
          chosen_bin_r <= BIN_OUT_W'(chosen_r);
          status_r     <= STATUS_OK;
        end
        RES_ZERO: begin
          energy_r     <= '0;
          chosen_bin_r <= BIN_OUT_W'(chosen_r);
          status_r     <= STATUS_OK;
        end
        default: begin
          energy_r     <= '0;
          chosen_bin_r <= '0;
          status_r     <= STATUS_EMPTY;
        end
      endcase
    end
  end

  hics_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_r),
    .den   ({w_r, {(DEN_W - W_W){1'b0}}}),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    stat.clr_last   = di_r == ADDR_W'(MAX_BINS - 1);
    stat.op         = op_r[0];
    stat.total_zero = total_r == '0;
    stat.hit        = hit;
    stat.miss       = !hit && (di_r == last_r);
    stat.at_first   = di_r == '0;
    stat.div_done   = div_done;
    stat.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid      = out_valid_r;
  assign out_energy     = energy_r;
  assign out_chosen_bin = chosen_bin_r;
  assign out_status     = status_r;

endmodule

// ----- sv/hics_ctrl.sv -----
// Controller state machine of the sampler: sequences clearing, writes and draws.
// Depends on hics_pkg for the command and status structs.
module hics_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hics_pkg::hics_stat_t  stat,
  output hics_pkg::hics_cmd_t   cmd
);
  import hics_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_WR_UPD,
    S_WALK,
    S_SUB,
    S_MUL,
    S_DIV_GO,
    S_DIV,
    S_FIN
  } state_t;

  state_t    state_r, state_nxt;
  res_kind_t kind_r, kind_nxt;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    cmd.kind  = kind_r;
    in_ready  = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.op == OP_WRITE) begin
          cmd.wr_read = 1'b1;
          state_nxt   = S_WR_UPD;
        end else begin
          cmd.draw_start = 1'b1;
          if (stat.total_zero) begin
            kind_nxt  = RES_EMPTY;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WR_UPD: begin
        cmd.wr_update = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.hit) begin
          if (stat.at_first) begin
            kind_nxt  = RES_ZERO;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SUB;
          end
        end else if (stat.miss) begin
          kind_nxt  = RES_ZERO;
          state_nxt = S_FIN;
        end
      end
      S_SUB: begin
        cmd.sub   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          kind_nxt  = RES_CALC;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      kind_r  <= RES_EMPTY;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

// ----- sv/histogram_inverse_cdf_sampler_top.sv -----
// Top level of the histogram inverse-CDF sampler: channel wiring, controller and datapath.
// Depends on hics_pkg, the interfaces in hics_if.sv, hics_ctrl and hics_dp.
//
// This block draws energies from a histogram spectrum by inverse transform
// sampling. Write items (opcode 0) store one 16-bit bin weight and keep the
// running total up to date; they produce no result. Draw items (opcode 1)
// bring a U0.24 uniform fraction u, walk the bins in use from bin 0, summing
// weights until the partial sum reaches u times the total, and then
// interpolate linearly inside the hit bin, giving one result item with the
// energy in U17.8 keV, the chosen bin and a status (1 when the table is
// empty). Hitting bin 0 gives energy 0, and a walk that ends without reaching
// the target gives energy 0 with the last bin in use. After reset the block
// clears all MAX_BINS (512) entries of the weight memory, one entry per
// cycle, and takes no item during that time; configuration writes are taken
// at any time and the configuration channel is always ready, but registers
// should only be changed while the block is idle. One item is worked on at a
// time. A write item passes through the decode and update states before the
// block is ready again. A draw walks the bins, reading one weight per cycle
// through the single read port of the weight memory, and the interpolation
// then runs a restoring divider that produces one of its 16 quotient bits per
// cycle. A draw at bin 0, and one on an empty table, skip the interpolation
// and go straight to the result. The longest draw walks all bins in use. The
// result sits in an output register; a following item is accepted while it
// waits, and only a finished draw waits for that register to drain.
module histogram_inverse_cdf_sampler_top (
  input  logic   clk,
  input  logic   rst_n,
  hics_in_if.sink     in_if,
  hics_out_if.source  out_if,
  hics_cfg_if.sink    cfg_if
);
  import hics_pkg::*;

  hics_cmd_t  cmd;
  hics_stat_t stat;
  logic       in_ready;
  logic       cfg_we;

  // The configuration registers take a write in any cycle.
  assign cfg_if.ready = 1'b1;
  assign cfg_we       = cfg_if.valid;

  assign in_if.ready = in_ready;

  hics_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hics_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_if.opcode),
    .in_bin_index     (in_if.bin_index),
    .in_bin_weight    (in_if.bin_weight),
    .in_uniform_value (in_if.uniform_value),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_if.index),
    .cfg_data         (cfg_if.data),
    .out_ready        (out_if.ready),
    .out_valid        (out_if.valid),
    .out_energy       (out_if.energy),
    .out_chosen_bin   (out_if.chosen_bin),
    .out_status       (out_if.status)
  );

endmodule
